FILE: design/mfb_crc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfb_crc_pkg;

   // frame layout
   localparam int MAX_PAYLOAD = 102;
   localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
   localparam int HDR_LEN     = 23;
   localparam int HDR_IDX_W   = $clog2(HDR_LEN);
   localparam int HDR_W       = HDR_LEN * 8;

   // fixed header bytes
   localparam logic [7:0] FRAME_CTRL_LO = 8'h01;
   localparam logic [7:0] FRAME_CTRL_HI = 8'hCC;
   localparam logic [7:0] SEQ_NUM       = 8'h00;

   // reflected crc-16
   localparam logic [15:0] CRC_POLY = 16'h8408;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_PAN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEST_ADDR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_PAN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_ADDR  = 2'd3;

   // phase of the request in hand
   typedef enum logic [4:0] {
      PH_START  = 5'b00001,
      PH_HDR    = 5'b00010,
      PH_DATA   = 5'b00100,
      PH_CRC_HI = 5'b01000,
      PH_CRC_LO = 5'b10000
   } phase_type;

   // one byte through the crc, lsb first
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      logic [7:0]  b;
      c = crc;
      b = data;
      for (int k = 0; k < 8; k++) begin
         if (c[0] ^ b[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
         b = b >> 1;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: design/mac_frame_builder_crc16_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Data frame builder with CRC-16 trailer.
// Request channel (req_*): one payload byte per request, with end_of_payload on the
// last byte of a frame and empty_frame for a frame without payload. Response channel
// (rsp_*): the frame, one byte per response; end_of_frame marks the second CRC byte,
// too_long on it reports payload bytes dropped beyond the payload limit.
// Config channel (csr_*): writes the PAN ids and addresses, always ready; write only
// while no frame byte is pending.
// Throughput: the first request of a frame also emits the 23-byte header, the last one
// the two CRC bytes; the single byte sequencer emits one response per cycle while the
// receiver does not stall, and takes a new request in the cycle the one in hand
// finishes. Dropped bytes give no response.
// An accepted request is held in the request register, and its responses are held in
// the output register that drives rsp_*.
// Reset clears the config registers to zero and the frame state to its start, the CRC
// to its initial value. When the receiver stalls, the output register holds its byte,
// the sequencer waits and req_stall rises once the request in hand cannot finish.
module mac_frame_builder_crc16_core
   import mfb_crc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [7:0]           req_payload_byte,
   input  wire logic                 req_end_of_payload,
   input  wire logic                 req_empty_frame,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [7:0]                rsp_frame_byte,
   output logic                      rsp_end_of_frame,
   output logic                      rsp_too_long,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [63:0]          csr_wdata
);

   // config registers
   logic [15:0] dest_pan_ff, src_pan_ff;
   logic [63:0] dest_addr_ff, src_addr_ff;

   // request in hand
   logic                 cur_valid_ff, cur_valid_in;
   logic [7:0]           cur_byte_ff;
   logic                 cur_last_ff, cur_empty_ff;
   phase_type            ph_ff, ph_in;
   logic [HDR_IDX_W-1:0] idx_ff, idx_in;

   // frame state
   logic [15:0]      crc_ff, crc_in;
   logic             in_frame_ff, in_frame_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;

   // output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_eof_ff, rsp_eof_in;
   logic       rsp_tl_ff, rsp_tl_in;

   logic            count_full;
   phase_type       after_ph, eff_ph;
   logic            after_none, after_ovf, eff_none, eff_ovf;
   logic            out_free, step_fire, step_emit, step_done, req_accept;
   logic [HDR_W-1:0] hdr_vec;
   logic [15:0]     crc_inv;

   assign csr_ready = 1'b1;
   assign count_full = (count_ff >= CNT_W'(MAX_PAYLOAD));
   assign hdr_vec = {src_addr_ff, src_pan_ff, dest_addr_ff, dest_pan_ff,
                     SEQ_NUM, FRAME_CTRL_HI, FRAME_CTRL_LO};
   assign crc_inv = ~crc_ff;

   // what follows the header (or a byte inside a frame)
   always_comb begin
      after_ph   = PH_DATA;
      after_none = 1'b0;
      after_ovf  = 1'b0;
      priority if (cur_empty_ff) begin
         after_ph = PH_CRC_HI;
      end else if (!count_full) begin
         after_ph = PH_DATA;
      end else begin
         after_ovf = 1'b1;
         if (cur_last_ff) begin
            after_ph = PH_CRC_HI;
         end else begin
            after_none = 1'b1;
         end
      end
   end

   // effective phase this cycle
   always_comb begin
      eff_ph   = ph_ff;
      eff_none = 1'b0;
      eff_ovf  = 1'b0;
      if (ph_ff == PH_START) begin
         if (!in_frame_ff) begin
            eff_ph = PH_HDR;
         end else begin
            eff_ph   = after_ph;
            eff_none = after_none;
            eff_ovf  = after_ovf;
         end
      end
   end

   // handshake
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign step_fire  = cur_valid_ff && (eff_none || out_free);
   assign step_emit  = step_fire && !eff_none;
   assign step_done  = step_fire && (eff_none
                       || (eff_ph == PH_DATA && !cur_last_ff) || eff_ph == PH_CRC_LO);
   assign req_stall  = cur_valid_ff && !step_done;
   assign req_accept = req_valid && !req_stall;

   // sequencer and frame state
   always_comb begin
      ph_in        = ph_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      in_frame_in  = in_frame_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_eof_in   = 1'b0;
      rsp_tl_in    = 1'b0;
      cur_valid_in = req_accept ? 1'b1 : (step_done ? 1'b0 : cur_valid_ff);
      rsp_valid_in = out_free ? step_emit : rsp_valid_ff;
      if (!out_free) begin
         rsp_eof_in = rsp_eof_ff;
         rsp_tl_in  = rsp_tl_ff;
      end
      if (step_fire && eff_ovf) begin
         ovf_in = 1'b1;
      end
      // a dropped byte leaves the crc, the count and the output alone
      if (step_emit) begin
         unique case (eff_ph)
            PH_HDR: begin
               rsp_byte_in = hdr_vec[{idx_ff, 3'b000} +: 8];
               in_frame_in = 1'b1;
               if (idx_ff == HDR_IDX_W'(HDR_LEN - 1)) begin
                  ph_in = after_ph;
               end else begin
                  ph_in  = PH_HDR;
                  idx_in = idx_ff + 1'b1;
               end
            end
            PH_DATA: begin
               rsp_byte_in = cur_byte_ff;
               crc_in      = crc16_byte(crc_ff, cur_byte_ff);
               count_in    = count_ff + 1'b1;
               ph_in       = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               rsp_byte_in = crc_inv[15:8];
               ph_in       = PH_CRC_LO;
            end
            PH_CRC_LO: begin
               rsp_byte_in = crc_inv[7:0];
               rsp_eof_in  = 1'b1;
               rsp_tl_in   = ovf_ff;
               crc_in      = CRC_INIT;
               in_frame_in = 1'b0;
               count_in    = '0;
               ovf_in      = 1'b0;
            end
            default: begin
               ph_in = ph_ff;
            end
         endcase
      end
      // a new request starts over
      if (req_accept) begin
         ph_in  = PH_START;
         idx_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         ph_ff        <= PH_START;
         idx_ff       <= '0;
         crc_ff       <= CRC_INIT;
         in_frame_ff  <= 1'b0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_eof_ff   <= 1'b0;
         rsp_tl_ff    <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         ph_ff        <= ph_in;
         idx_ff       <= idx_in;
         crc_ff       <= crc_in;
         in_frame_ff  <= in_frame_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_eof_ff   <= rsp_eof_in;
         rsp_tl_ff    <= rsp_tl_in;
      end
   end

   // request and response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cur_byte_ff  <= req_payload_byte;
         cur_last_ff  <= req_end_of_payload;
         cur_empty_ff <= req_empty_frame;
      end
      rsp_byte_ff <= rsp_byte_in;
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         dest_pan_ff  <= '0;
         dest_addr_ff <= '0;
         src_pan_ff   <= '0;
         src_addr_ff  <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEST_PAN:  dest_pan_ff  <= csr_wdata[15:0];
            CSR_DEST_ADDR: dest_addr_ff <= csr_wdata;
            CSR_SRC_PAN:   src_pan_ff   <= csr_wdata[15:0];
            CSR_SRC_ADDR:  src_addr_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_byte   = rsp_byte_ff;
   assign rsp_end_of_frame = rsp_eof_ff;
   assign rsp_too_long     = rsp_tl_ff;

   // checks
   a_tl_on_eof: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_long |-> rsp_end_of_frame)
      else $error("too_long outside the last frame byte");

   a_eof_closes: assert property (@(posedge clock) disable iff (reset)
      step_fire && eff_ph == PH_CRC_LO |=> !in_frame_ff && crc_ff == CRC_INIT)
      else $error("frame state not cleared after crc");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PAYLOAD))
      else $error("payload count beyond limit");

   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !cur_valid_ff |-> !req_stall)
      else $error("stall with no request in hand");

endmodule

`default_nettype wire
